// ----- rtl/core/cbf_pkg.sv -----
// Centred box filter: shared widths, limits and the divider request/response types.
// No dependencies; imported by the divider and the top level.
`timescale 1ns / 1ps

package cbf_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int HW_W       = 6;
  localparam int MAX_HALF   = 32;
  localparam int RING_DEPTH = 128;
  localparam int RING_AW    = 7;
  localparam int CNT_W      = 7;
  localparam int CNT_SAT    = 2 * MAX_HALF;
  localparam int SUM_W      = 23;
  localparam int MAG_W      = 22;
  localparam int DEN_W      = 7;
  localparam int STEP_W     = $clog2(MAG_W);

  localparam logic [STEP_W-1:0] DIV_LAST_STEP = STEP_W'(MAG_W - 1);

  typedef struct packed {
    logic               start;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [DEN_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [SAMPLE_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- rtl/core/cbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module cbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/cbf_div.sv -----
// Restoring divider, one quotient bit per cycle, sign applied on completion.
// Depends on cbf_pkg.
`timescale 1ns / 1ps

module cbf_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbf_pkg::div_req_t req_i,
  output cbf_pkg::div_rsp_t rsp_o
);
  import cbf_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                neg_q;
  logic [MAG_W-1:0]    acc_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W-1:0]    den_q;
  logic [SAMPLE_W-1:0] quot_q;

  logic [DEN_W:0]      rem_sh;
  logic [DEN_W:0]      rem_sub;
  logic                ge;
  logic [DEN_W-1:0]    rem_nx;
  logic [MAG_W-1:0]    acc_nx;
  logic [MAG_W-1:0]    acc_neg;

  always_comb begin
    rem_sh  = {rem_q, acc_q[MAG_W-1]};
    ge      = rem_sh >= {1'b0, den_q};
    rem_sub = rem_sh - {1'b0, den_q};
    rem_nx  = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    acc_nx  = {acc_q[MAG_W-2:0], ge};
    acc_neg = ~acc_nx + MAG_W'(1);
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      step_d = '0;
    end else if (busy_q) begin
      if (step_q == DIV_LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      acc_q <= req_i.mag;
      rem_q <= '0;
      den_q <= req_i.den;
      neg_q <= req_i.neg;
    end else if (busy_q) begin
      acc_q <= acc_nx;
      rem_q <= rem_nx;
      if (step_q == DIV_LAST_STEP) begin
        quot_q <= neg_q ? acc_neg[SAMPLE_W-1:0] : acc_nx[SAMPLE_W-1:0];
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// ----- rtl/core/centered_box_filter_core.sv -----
// Centred box filter top level: sequencer, sample ring, running sum, output register.
// Depends on cbf_pkg, cbf_ram and cbf_div.
//
// Usage: samples (Q2.13, signed) enter on the s_axis channel with tlast marking the
// end of a stream; results leave on m_axis in stream order, tlast on the final one.
// half_window (register 0 on the APB port, reset 1, saturated at 32) sets w; 0
// passes every item straight through. Otherwise item i is emitted once
// item i+w has arrived: from item w on, one filtered or passed item per input, plus
// the pending items (w, or all if the stream is shorter than w+1) flushed on tlast.
// Flow control: one item accepted at a time, s_axis_tready is high only when the
// sequencer is idle. A filtered item waits for the 22-step restoring divider
// (one quotient bit per cycle); a passed or pass-through item does not use it.
// A full output register stalls the sequencer until m_axis takes the item, so
// the output register lets one result wait while the next item is worked on.
// Reset clears counters, running sum and output valid; the ring needs no clearing
// since it is only read where the current stream has written. A register write
// aborts the stream in progress and drops its pending items.
`timescale 1ns / 1ps

module centered_box_filter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: sample[15:0]
  input  logic [15:0] s_axis_tdata_i,
  input  logic        s_axis_tlast_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // tdata: value[15:0]
  output logic [15:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);
  import cbf_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PASS = 4'd1;
  localparam logic [3:0] S_READ = 4'd2;
  localparam logic [3:0] S_WAIT = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_OUT  = 4'd5;
  localparam logic [3:0] S_LCHK = 4'd6;
  localparam logic [3:0] S_FRD  = 4'd7;
  localparam logic [3:0] S_FWT  = 4'd8;

  localparam logic ADDR_HALF_WINDOW = 1'b0;

  logic [3:0]          state_q, state_d;
  logic [HW_W-1:0]     hw_q, hw_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [RING_AW-1:0]  ptr_q, ptr_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [RING_AW-1:0]  rp_q, rp_d;
  logic [HW_W-1:0]     rem_q, rem_d;
  logic                out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0] out_value_q, out_value_d;
  logic                out_last_q, out_last_d;
  logic [SAMPLE_W-1:0] x_q, x_d;
  logic                last_q, last_d;
  logic [SAMPLE_W-1:0] hold_q, hold_d;

  logic                cfg_we;
  logic [HW_W-1:0]     w_eff;
  logic [DEN_W-1:0]    w2;
  logic                emit;
  logic                full;
  logic [HW_W-1:0]     pending;
  logic [SUM_W-1:0]    x_ext;
  logic [SUM_W-1:0]    rd_ext;
  logic [SUM_W-1:0]    sum_neg;
  logic                out_free;
  logic                out_load;
  logic [SAMPLE_W-1:0] load_value;
  logic                load_last;

  logic                ram_we;
  logic                ram_re;
  logic [RING_AW-1:0]  ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg_we   = psel_i && penable_i && pwrite_i && (paddr_i[2] == ADDR_HALF_WINDOW);
  assign pready_o = 1'b1;
  assign prdata_o = 32'(hw_q);

  always_comb begin
    w_eff   = (hw_q > HW_W'(MAX_HALF)) ? HW_W'(MAX_HALF) : hw_q;
    w2      = {w_eff, 1'b0};
    emit    = cnt_q >= CNT_W'(w_eff);
    full    = cnt_q >= CNT_W'(w2);
    pending = emit ? w_eff : (cnt_q[HW_W-1:0] + HW_W'(1));
    x_ext   = {{(SUM_W-SAMPLE_W){x_q[SAMPLE_W-1]}}, x_q};
    rd_ext  = {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
    sum_neg = ~sum_q + SUM_W'(1);
    out_free = !out_valid_q || m_axis_tready_i;
  end

  assign div_req.start = (state_q == S_READ) && full;
  assign div_req.neg   = sum_q[SUM_W-1];
  assign div_req.mag   = sum_q[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_q[MAG_W-1:0];
  assign div_req.den   = w2;

  always_comb begin
    state_d    = state_q;
    hw_d       = hw_q;
    sum_d      = sum_q;
    ptr_d      = ptr_q;
    cnt_d      = cnt_q;
    rp_d       = rp_q;
    rem_d      = rem_q;
    x_d        = x_q;
    last_d     = last_q;
    hold_d     = hold_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = rp_q;
    out_load   = 1'b0;
    load_value = ram_rdata;
    load_last  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          x_d     = s_axis_tdata_i;
          last_d  = s_axis_tlast_i;
          state_d = (w_eff == '0) ? S_PASS : S_READ;
        end
      end
      S_PASS: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_value = x_q;
          load_last  = last_q;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        ram_we    = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = ptr_q - (full ? RING_AW'(w2) : RING_AW'(w_eff));
        state_d   = S_WAIT;
      end
      S_WAIT: begin
        hold_d = ram_rdata;
        sum_d  = sum_q + x_ext - (full ? rd_ext : '0);
        if (!emit) begin
          state_d = S_LCHK;
        end else if (full) begin
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          load_value = full ? div_rsp.quot : hold_q;
          state_d    = S_LCHK;
        end
      end
      S_LCHK: begin
        if (last_q) begin
          rp_d    = ptr_q + RING_AW'(1) - RING_AW'(pending);
          rem_d   = pending;
          state_d = S_FRD;
        end else begin
          ptr_d   = ptr_q + RING_AW'(1);
          cnt_d   = (cnt_q == CNT_W'(CNT_SAT)) ? cnt_q : cnt_q + CNT_W'(1);
          state_d = S_IDLE;
        end
      end
      S_FRD: begin
        ram_re  = 1'b1;
        state_d = S_FWT;
      end
      S_FWT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_last = (rem_q == HW_W'(1));
          rp_d      = rp_q + RING_AW'(1);
          rem_d     = rem_q - HW_W'(1);
          if (rem_q == HW_W'(1)) begin
            sum_d   = '0;
            ptr_d   = '0;
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            state_d = S_FRD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      hw_d  = pwdata_i[HW_W-1:0];
      sum_d = '0;
      ptr_d = '0;
      cnt_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_value_d = load_value;
      out_last_d  = load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      hw_q        <= HW_W'(1);
      sum_q       <= '0;
      ptr_q       <= '0;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      sum_q       <= sum_d;
      ptr_q       <= ptr_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q        <= rp_d;
    x_q         <= x_d;
    last_q      <= last_d;
    hold_q      <= hold_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
  end

  cbf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ptr_q),
    .wdata_i (x_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  cbf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tlast_o  = out_last_q;

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("output register overwritten");

  a_flush_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FWT) |-> (rem_q != '0))
    else $error("flush with no pending item");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_DIV))
    else $error("quotient arrived outside divide wait");

endmodule

// ----- bench/tb_top.sv -----
// Testbench for centered_box_filter_core: streams of Q2.13 samples under several
// half-window settings, results checked against a local centred moving-average predictor.
// Depends on cbf_pkg and the RTL of centered_box_filter_core only.
`timescale 1ns / 1ps

module tb_top;
  import cbf_pkg::*;

  localparam logic [2:0] HALF_WINDOW_ADDR = 3'd0;
  localparam int         CYCLE_LIMIT      = 200000;
  localparam int         SETTLE_CYCLES    = 60;
  localparam int         RANDOM_ITEMS     = 80;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] value;
    logic                last;
  } out_item_t;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic [15:0]         s_axis_tdata_i  = '0;
  logic                s_axis_tlast_i  = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [15:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic                psel_i          = 1'b0;
  logic                penable_i       = 1'b0;
  logic                pwrite_i        = 1'b0;
  logic [2:0]          paddr_i         = '0;
  logic [31:0]         pwdata_i        = '0;
  logic [31:0]         prdata_o;
  logic                pready_o;

  // predictor state
  logic [HW_W-1:0]            cfg_half = 6'd1;
  logic signed [SAMPLE_W-1:0] orig_ring [RING_DEPTH];
  logic signed [SUM_W-1:0]    win_sum  = '0;
  logic [31:0]                n_in     = '0;

  in_item_t  sample_q [$];
  out_item_t filtered_q [$];
  in_item_t  cur_item;
  out_item_t want;
  bit        item_taken = 1'b0;
  bit        no_idle    = 1'b0;
  int        n_errors   = 0;
  int        cycles     = 0;
  int        rand_items = 0;

  centered_box_filter_core u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  task automatic push_filtered(input logic [SAMPLE_W-1:0] v, input logic l);
    out_item_t o;
    o.value = v;
    o.last  = l;
    filtered_q.push_back(o);
  endtask

  // one accepted sample: emits the output w places back, flushes the tail on last
  task automatic box_filter_step(input logic signed [SAMPLE_W-1:0] x, input logic lst);
    logic [HW_W-1:0]        w;
    logic [DEN_W-1:0]       w2;
    logic [31:0]            k, idx, pend, first;
    logic signed [SUM_W-1:0] q;
    begin
      w  = (cfg_half > MAX_HALF) ? HW_W'(MAX_HALF) : cfg_half;
      w2 = {w, 1'b0};
      k  = n_in;
      if (w == 0) begin
        push_filtered(x, lst);
      end else begin
        if (k >= w) begin
          if (k >= w2) begin
            q = win_sum / $signed({16'd0, w2});
            push_filtered(q[SAMPLE_W-1:0], 1'b0);
          end else begin
            idx = k - w;
            push_filtered(orig_ring[idx[RING_AW-1:0]], 1'b0);
          end
        end
        orig_ring[k[RING_AW-1:0]] = x;
        win_sum = win_sum + x;
        if (k >= w2) begin
          idx = k - w2;
          win_sum = win_sum - orig_ring[idx[RING_AW-1:0]];
        end
        if (lst) begin
          pend  = (k >= w) ? 32'(w) : k + 1;
          first = k + 1 - pend;
          for (int t = 0; t < pend; t++) begin
            idx = first + t;
            push_filtered(orig_ring[idx[RING_AW-1:0]], (t + 1) == pend);
          end
          win_sum = '0;
          n_in    = '0;
        end else begin
          n_in = (n_in == 32'hFFFF_FFFF) ? 32'h8000_0000 : n_in + 1;
        end
      end
    end
  endtask

  // sender: a new item goes out at the falling edge once the previous one was taken
  always @(negedge clk_i) begin
    m_axis_tready_i <= no_idle || ($urandom_range(99) >= 9);
    if (rst_ni && (item_taken || !s_axis_tvalid_i)) begin
      if (sample_q.size() != 0 && (no_idle || $urandom_range(99) >= 9)) begin
        cur_item = sample_q.pop_front();
        s_axis_tdata_i  <= cur_item.sample;
        s_axis_tlast_i  <= cur_item.last;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
    item_taken = 1'b0;
  end

  // input acceptance, output checking and the cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
        box_filter_step(s_axis_tdata_i, s_axis_tlast_i);
        item_taken = 1'b1;
      end
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        if (filtered_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected item value %h last %b",
                                  m_axis_tdata_o, m_axis_tlast_o));
        end else begin
          want = filtered_q.pop_front();
          if (m_axis_tdata_o !== want.value)
            flag_mismatch($sformatf("value %h, expected %h", m_axis_tdata_o, want.value));
          if (m_axis_tlast_o !== want.last)
            flag_mismatch($sformatf("tlast %b, expected %b", m_axis_tlast_o, want.last));
        end
      end
    end
  end

  task automatic wait_drained();
    while (sample_q.size() != 0 || s_axis_tvalid_i || filtered_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write half_window, then read it back; the write aborts any open stream
  task automatic set_half_window(input logic [HW_W-1:0] val);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= HALF_WINDOW_ADDR;
    pwdata_i  <= {26'd0, val};
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    cfg_half = val;
    win_sum  = '0;
    n_in     = '0;
    @(negedge clk_i);
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    if (prdata_o[HW_W-1:0] !== val)
      flag_mismatch($sformatf("half_window reads %h, expected %h", prdata_o, val));
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
  endtask

  task automatic push_sample(input logic [SAMPLE_W-1:0] s, input logic l);
    in_item_t it;
    it.sample = s;
    it.last   = l;
    sample_q.push_back(it);
  endtask

  task automatic queue_stream(input int len, input bit ends, input int pause_at);
    logic [SAMPLE_W-1:0] s;
    for (int i = 0; i < len; i++) begin
      if (pause_at != 0 && i == pause_at)
        wait_drained();
      case ($urandom_range(7))
        0:       s = 16'h7FFF;
        1:       s = 16'h8000;
        default: s = SAMPLE_W'($urandom);
      endcase
      push_sample(s, ends && (i == len - 1));
      rand_items++;
    end
  endtask

  initial begin
    int phase_no;
    int hw, effw, nstreams, len;
    bit ends;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting w = 1: short stream, then a one-sample stream
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'hFFFF, 1'b1);
    wait_drained();

    // bypass
    set_half_window(6'd0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b1);
    push_sample(16'h5555, 1'b0);
    wait_drained();

    // above the maximum, saturates; stream shorter than w+1
    set_half_window(6'd63);
    for (int i = 0; i < 5; i++)
      push_sample(16'hAAAA ^ 16'(i), i == 4);
    wait_drained();

    // w = 2: full-scale and negative averages, then an open stream that the next write drops
    set_half_window(6'd2);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'hFFFF, 1'b0);
    push_sample(16'hFFFE, 1'b0);
    push_sample(16'h0003, 1'b1);
    push_sample(16'h1234, 1'b0);
    push_sample(16'hEDCB, 1'b0);
    push_sample(16'h0001, 1'b0);
    wait_drained();

    phase_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if (phase_no == 0) begin
        hw = MAX_HALF;
      end else begin
        case ($urandom_range(9))
          0:       hw = 0;
          1:       hw = $urandom_range(33, 63);
          default: hw = $urandom_range(1, 6);
        endcase
      end
      effw = (hw > MAX_HALF) ? MAX_HALF : hw;
      set_half_window(HW_W'(hw));
      if (phase_no == 0) begin
        no_idle = 1'b1;
        queue_stream(2 * MAX_HALF + 3, 1'b1, 0);
      end else begin
        nstreams = $urandom_range(1, 3);
        for (int s = 0; s < nstreams; s++) begin
          if (hw == 0 || effw == MAX_HALF)
            len = $urandom_range(1, 12);
          else if ($urandom_range(3) != 0)
            len = 2 * effw + 1 + $urandom_range(0, 10);
          else
            len = $urandom_range(1, 2 * effw);
          ends = (s < nstreams - 1) || ($urandom_range(4) != 0);
          queue_stream(len, ends, (phase_no == 1 && s == 0) ? len / 2 : 0);
        end
      end
      wait_drained();
      no_idle = 1'b0;
      phase_no++;
    end

    wait_drained();
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/cbf_pkg.sv
rtl/core/cbf_ram.sv
rtl/core/cbf_div.sv
rtl/core/centered_box_filter_core.sv
bench/tb_top.sv
